FILE: rtl/jsu_pkg.sv
// Shared types, constants and helper functions for the JSON string unescaper.
// Used by jsu_ctrl, jsu_dpath and json_string_unescape_core; depends on nothing.

package jsu_pkg;

	// Depth of the window that holds an undecided escape plus the new byte.
	localparam int HOLD_DEPTH = 11;
	localparam int CNT_W      = 4;
	localparam int CP_W       = 21;

	// Characters that steer the scanner.
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_U      = 8'h75;

	// Bytes consumed by one scan step.
	localparam logic [CNT_W-1:0] USED_CHAR = 4'd1;
	localparam logic [CNT_W-1:0] USED_UNIT = 4'd5;
	localparam logic [CNT_W-1:0] USED_PAIR = 4'd11;

	// Surrogate ranges and the replacement character.
	localparam logic [15:0] HI_SURR_MIN = 16'hD800;
	localparam logic [15:0] HI_SURR_MAX = 16'hDBFF;
	localparam logic [15:0] LO_SURR_MIN = 16'hDC00;
	localparam logic [15:0] LO_SURR_MAX = 16'hDFFF;
	localparam logic [CP_W-1:0] CP_REPLACE = 21'h00FFFD;
	localparam logic [CP_W-1:0] CP_SUPP_BASE = 21'h010000;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_final;
	} item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_valid;
		logic       out_last;
		logic       string_done;
		logic       unterminated;
	} result_t;

	// What the byte at the head of the window calls for.
	typedef enum logic [2:0] {
		ACT_END,
		ACT_QUOTE,
		ACT_WAIT,
		ACT_ESC,
		ACT_CHAR
	} act_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_LOAD,
		OP_STEP,
		OP_EMIT,
		OP_FINISH
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		act_t act;
		logic push_ok;
		logic out_free;
		logic multi;
		logic emit_last;
	} st_t;

	// Returns {ok, value} for one hex digit.
	function automatic logic [4:0] hex_nibble(input logic [7:0] c);
		logic [4:0] r;
		r = '0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, 4'(c - 8'h30)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r = {1'b1, 4'(c - 8'h57)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b1, 4'(c - 8'h37)};
		end
		return r;
	endfunction

	// Maps the character after a backslash; unknown ones pass through.
	function automatic logic [7:0] simple_escape(input logic [7:0] e);
		logic [7:0] r;
		case (e)
			8'h62: r = 8'h08;  // b
			8'h66: r = 8'h0C;  // f
			8'h6E: r = 8'h0A;  // n
			8'h72: r = 8'h0D;  // r
			8'h74: r = 8'h09;  // t
			default: r = e;
		endcase
		return r;
	endfunction

	// Index of the last UTF-8 byte for a code point (length minus one).
	function automatic logic [1:0] utf8_last(input logic [CP_W-1:0] cp);
		logic [1:0] r;
		if (cp < 21'h000080) begin
			r = 2'd0;
		end else if (cp < 21'h000800) begin
			r = 2'd1;
		end else if (cp < 21'h010000) begin
			r = 2'd2;
		end else begin
			r = 2'd3;
		end
		return r;
	endfunction

	// Byte k of the UTF-8 encoding whose last index is last.
	function automatic logic [7:0] utf8_byte(input logic [CP_W-1:0] cp,
	                                         input logic [1:0] last,
	                                         input logic [1:0] k);
		logic [7:0] r;
		case (last)
			2'd0: r = cp[7:0];
			2'd1: r = (k == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
			2'd2: begin
				case (k)
					2'd0: r = {4'b1110, cp[15:12]};
					2'd1: r = {2'b10, cp[11:6]};
					default: r = {2'b10, cp[5:0]};
				endcase
			end
			default: begin
				case (k)
					2'd0: r = {5'b11110, cp[20:18]};
					2'd1: r = {2'b10, cp[17:12]};
					2'd2: r = {2'b10, cp[11:6]};
					default: r = {2'b10, cp[5:0]};
				endcase
			end
		endcase
		return r;
	endfunction

endpackage

FILE: rtl/json_string_unescape_core.sv
// Top level of the JSON string unescaper: sequencer, datapath and the
// result register. Depends on jsu_pkg, jsu_ctrl and jsu_dpath.
//
//   channel   direction   handshake                    payload
//   item      in          item_valid / item_stall      jsu_pkg::item_t
//   result    out         result_valid / result_stall  jsu_pkg::result_t
//
// A request of plain text is worked as a load, a scan step and a close.
// Each further scan step is one per backslash or decoded character, and
// every UTF-8 byte after a character's first takes its own emit step; bytes
// of a held escape that turns out bad are scanned again one per cycle while
// the result side lets the scanner run. One request is worked at a time.
// Reset clears the control state; the held escape bytes are undefined.
// Result stall holds the scanner once the holdback byte and the result
// register are both full, and holds the close until the register is free.

module json_string_unescape_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  jsu_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_stall,
	output jsu_pkg::result_t result
);

	jsu_pkg::cmd_t    cmd;
	jsu_pkg::st_t     st;
	logic             out_free;
	logic             res_load;
	jsu_pkg::result_t res_data;
	logic             result_valid_q;
	jsu_pkg::result_t result_q;

	jsu_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.st         (st),
		.cmd        (cmd)
	);

	jsu_dpath u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.cmd      (cmd),
		.out_free (out_free),
		.st       (st),
		.res_load (res_load),
		.res_data (res_data)
	);

	// The result register can take a byte when empty or being drained.
	assign out_free = !result_valid_q || !result_stall;

	// Result register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (res_load) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (res_load) begin
			result_q <= res_data;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// A result is never written over one that is still stalled.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |-> out_free)
		else $error("result register overwritten while stalled");

	// An unterminated flag only comes with the end of the string.
	a_unterm_done: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.unterminated) |-> result.string_done)
		else $error("unterminated without string end");

	// An empty result only marks the end of a string.
	a_empty_done: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result.out_valid) |-> result.string_done && result.out_last)
		else $error("empty result outside string end");

endmodule

FILE: rtl/jsu_ctrl.sv
// Sequencer of the JSON string unescaper: takes a request, steps the scanner
// and emits the bytes of multi-byte characters. Depends on jsu_pkg.

module jsu_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          item_valid,
	output logic          item_stall,
	input  jsu_pkg::st_t  st,
	output jsu_pkg::cmd_t cmd
);

	jsu_pkg::state_t state_q;
	jsu_pkg::state_t state_d;
	logic            closing;

	// The window has nothing left to decide for this request.
	assign closing = (st.act == jsu_pkg::ACT_END) || (st.act == jsu_pkg::ACT_QUOTE) ||
	                 (st.act == jsu_pkg::ACT_WAIT);

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= jsu_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			jsu_pkg::ST_IDLE: begin
				if (item_valid) begin
					state_d = jsu_pkg::ST_SCAN;
				end
			end
			jsu_pkg::ST_SCAN: begin
				if (closing && st.out_free) begin
					state_d = jsu_pkg::ST_IDLE;
				end else if (st.act == jsu_pkg::ACT_CHAR && st.push_ok && st.multi) begin
					state_d = jsu_pkg::ST_EMIT;
				end
			end
			jsu_pkg::ST_EMIT: begin
				if (st.push_ok && st.emit_last) begin
					state_d = jsu_pkg::ST_SCAN;
				end
			end
			default: state_d = jsu_pkg::ST_IDLE;
		endcase
	end

	// Commands to the datapath.
	always_comb begin
		cmd.op     = jsu_pkg::OP_NONE;
		item_stall = 1'b1;
		case (state_q)
			jsu_pkg::ST_IDLE: begin
				item_stall = 1'b0;
				if (item_valid) begin
					cmd.op = jsu_pkg::OP_LOAD;
				end
			end
			jsu_pkg::ST_SCAN: begin
				if (closing) begin
					if (st.out_free) begin
						cmd.op = jsu_pkg::OP_FINISH;
					end
				end else if (st.act == jsu_pkg::ACT_ESC) begin
					cmd.op = jsu_pkg::OP_STEP;
				end else if (st.push_ok) begin
					cmd.op = jsu_pkg::OP_STEP;
				end
			end
			jsu_pkg::ST_EMIT: begin
				if (st.push_ok) begin
					cmd.op = jsu_pkg::OP_EMIT;
				end
			end
			default: cmd.op = jsu_pkg::OP_NONE;
		endcase
	end

endmodule

FILE: rtl/jsu_dpath.sv
// Datapath of the JSON string unescaper: byte window, escape decoder, UTF-8
// encoder and a one-byte holdback that lets the last result be marked.
// Depends on jsu_pkg.

module jsu_dpath (
	input  logic             clk,
	input  logic             arst_n,
	input  jsu_pkg::item_t   item,
	input  jsu_pkg::cmd_t    cmd,
	input  logic             out_free,
	output jsu_pkg::st_t     st,
	output logic             res_load,
	output jsu_pkg::result_t res_data
);

	logic [jsu_pkg::HOLD_DEPTH-1:0][7:0] buf_q;
	logic [jsu_pkg::CNT_W-1:0]           cnt_q;
	logic                                esc_q;
	logic                                fin_q;
	logic [jsu_pkg::CP_W-1:0]            cp_q;
	logic [1:0]                          last_q;
	logic [1:0]                          k_q;
	logic [7:0]                          pend_q;
	logic                                pend_valid_q;

	logic [4:0]                n1, n2, n3, n4, m1, m2, m3, m4;
	logic                      hi_ok, lo_ok, is_hi, is_lo1, is_lo2, pair_ok;
	logic [15:0]               cu1, cu2;
	jsu_pkg::act_t             act;
	logic [jsu_pkg::CP_W-1:0]  cp_d;
	logic                      cp_unit;
	logic [1:0]                last_d;
	logic [jsu_pkg::CNT_W-1:0] used_d;
	logic                      push;
	logic [7:0]                push_byte;
	logic                      done;
	logic                      unterm;

	// Hex digits of the first and of a following code unit.
	always_comb begin
		n1     = jsu_pkg::hex_nibble(buf_q[1]);
		n2     = jsu_pkg::hex_nibble(buf_q[2]);
		n3     = jsu_pkg::hex_nibble(buf_q[3]);
		n4     = jsu_pkg::hex_nibble(buf_q[4]);
		m1     = jsu_pkg::hex_nibble(buf_q[7]);
		m2     = jsu_pkg::hex_nibble(buf_q[8]);
		m3     = jsu_pkg::hex_nibble(buf_q[9]);
		m4     = jsu_pkg::hex_nibble(buf_q[10]);
		hi_ok  = n1[4] & n2[4] & n3[4] & n4[4];
		lo_ok  = m1[4] & m2[4] & m3[4] & m4[4];
		cu1    = {n1[3:0], n2[3:0], n3[3:0], n4[3:0]};
		cu2    = {m1[3:0], m2[3:0], m3[3:0], m4[3:0]};
		is_hi  = (cu1 >= jsu_pkg::HI_SURR_MIN) && (cu1 <= jsu_pkg::HI_SURR_MAX);
		is_lo1 = (cu1 >= jsu_pkg::LO_SURR_MIN) && (cu1 <= jsu_pkg::LO_SURR_MAX);
		is_lo2 = (cu2 >= jsu_pkg::LO_SURR_MIN) && (cu2 <= jsu_pkg::LO_SURR_MAX);
		pair_ok = ((cnt_q < 4'd6) || (buf_q[5] == jsu_pkg::CH_BSLASH)) &&
		          ((cnt_q < 4'd7) || (buf_q[6] == jsu_pkg::CH_U));
	end

	// Decide what the head of the window yields. A bad or short escape
	// falls back to the 'u' itself, which is already the head byte.
	// Only a decoded \u escape is a code point; every other byte goes out as a single byte.
	always_comb begin
		act     = jsu_pkg::ACT_CHAR;
		cp_d    = {13'd0, buf_q[0]};
		cp_unit = 1'b0;
		used_d  = jsu_pkg::USED_CHAR;
		if (cnt_q == '0) begin
			act = jsu_pkg::ACT_END;
		end else if (!esc_q) begin
			if (buf_q[0] == jsu_pkg::CH_QUOTE) begin
				act = jsu_pkg::ACT_QUOTE;
			end else if (buf_q[0] == jsu_pkg::CH_BSLASH) begin
				act = jsu_pkg::ACT_ESC;
			end
		end else if (buf_q[0] != jsu_pkg::CH_U) begin
			cp_d = {13'd0, jsu_pkg::simple_escape(buf_q[0])};
		end else if (cnt_q < jsu_pkg::USED_UNIT) begin
			if (!fin_q) begin
				act = jsu_pkg::ACT_WAIT;
			end
		end else if (!hi_ok) begin
			cp_d = {13'd0, buf_q[0]};
		end else if (is_hi) begin
			used_d  = jsu_pkg::USED_UNIT;
			cp_d    = {5'd0, cu1};
			cp_unit = 1'b1;
			if (pair_ok && (cnt_q >= jsu_pkg::USED_PAIR)) begin
				if (lo_ok && is_lo2) begin
					cp_d   = jsu_pkg::CP_SUPP_BASE + {1'b0, cu1[9:0], cu2[9:0]};
					used_d = jsu_pkg::USED_PAIR;
				end else begin
					cp_d = jsu_pkg::CP_REPLACE;
				end
			end else if (pair_ok && !fin_q) begin
				act = jsu_pkg::ACT_WAIT;
			end
		end else begin
			used_d  = jsu_pkg::USED_UNIT;
			cp_d    = is_lo1 ? jsu_pkg::CP_REPLACE : {5'd0, cu1};
			cp_unit = 1'b1;
		end
	end

	// Byte produced this cycle, and the status seen by the sequencer.
	always_comb begin
		last_d = cp_unit ? jsu_pkg::utf8_last(cp_d) : 2'd0;
		push = ((cmd.op == jsu_pkg::OP_STEP) && (act == jsu_pkg::ACT_CHAR)) ||
		       (cmd.op == jsu_pkg::OP_EMIT);
		if (cmd.op == jsu_pkg::OP_EMIT) begin
			push_byte = jsu_pkg::utf8_byte(cp_q, last_q, k_q);
		end else begin
			push_byte = jsu_pkg::utf8_byte(cp_d, last_d, 2'd0);
		end
		done         = (act == jsu_pkg::ACT_QUOTE) || fin_q;
		unterm       = (act != jsu_pkg::ACT_QUOTE) && fin_q;
		st.act       = act;
		st.out_free  = out_free;
		st.push_ok   = !pend_valid_q || out_free;
		st.multi     = (last_d != 2'd0);
		st.emit_last = (k_q == last_q);
	end

	// A new byte pushes the held one out; closing the request flushes it
	// as the last result, or gives an empty result when the string ends.
	always_comb begin
		res_load = 1'b0;
		res_data = '{out_byte: pend_q, out_valid: 1'b1, out_last: 1'b0,
		             string_done: 1'b0, unterminated: 1'b0};
		if (push) begin
			res_load = pend_valid_q;
		end else if (cmd.op == jsu_pkg::OP_FINISH) begin
			res_data.out_last     = 1'b1;
			res_data.string_done  = done;
			res_data.unterminated = unterm;
			if (pend_valid_q) begin
				res_load = 1'b1;
			end else if (done) begin
				res_load          = 1'b1;
				res_data.out_byte  = '0;
				res_data.out_valid = 1'b0;
			end
		end
	end

	// Window fill, escape flag and holdback valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q        <= '0;
			esc_q        <= 1'b0;
			pend_valid_q <= 1'b0;
		end else begin
			case (cmd.op)
				jsu_pkg::OP_LOAD: begin
					cnt_q <= cnt_q + 4'd1;
				end
				jsu_pkg::OP_STEP: begin
					cnt_q <= cnt_q - used_d;
					esc_q <= (act == jsu_pkg::ACT_ESC);
				end
				jsu_pkg::OP_FINISH: begin
					pend_valid_q <= 1'b0;
					if (done) begin
						cnt_q <= '0;
						esc_q <= 1'b0;
					end
				end
				default: begin
				end
			endcase
			if (push) begin
				pend_valid_q <= 1'b1;
			end
		end
	end

	// Window bytes, current code point and emit index.
	always_ff @(posedge clk) begin
		case (cmd.op)
			jsu_pkg::OP_LOAD: begin
				buf_q[cnt_q] <= item.in_byte;
				fin_q        <= item.in_final;
			end
			jsu_pkg::OP_STEP: begin
				buf_q  <= buf_q >> {used_d, 3'b000};
				cp_q   <= cp_d;
				last_q <= last_d;
				k_q    <= 2'd1;
			end
			jsu_pkg::OP_EMIT: begin
				k_q <= k_q + 2'd1;
			end
			default: begin
			end
		endcase
		if (push) begin
			pend_q <= push_byte;
		end
	end

	// The window never grows past its depth.
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= jsu_pkg::USED_PAIR)
		else $error("window count out of range");

	// Bytes stay in the window between requests only inside an escape.
	a_load_held: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == jsu_pkg::OP_LOAD) |-> ((cnt_q == '0) || esc_q) &&
		(cnt_q < jsu_pkg::USED_PAIR))
		else $error("request loaded into a window that is not free");

	// Trailing UTF-8 bytes are emitted only for multi-byte characters.
	a_emit_index: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == jsu_pkg::OP_EMIT) |-> (last_q != 2'd0) && (k_q <= last_q))
		else $error("UTF-8 emit index out of range");

endmodule
